/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* design/tfn_pkg.sv */
// Widths, stage counts and pipeline payload types of the triangle face normal block.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package tfn_pkg;

	// Field widths.
	localparam int CW = 16;             // vertex coordinate, signed Q8.8
	localparam int OW = 16;             // normal component, signed Q1.14
	localparam int FB = 14;             // fraction bits of the normal

	// Internal arithmetic widths.
	localparam int EW  = CW + 1;        // edge difference
	localparam int PW  = 2 * EW;        // edge product
	localparam int NW  = PW + 1;        // cross product component
	localparam int MW  = NW - 1;        // cross product magnitude
	localparam int HW  = (MW + 1) / 2;  // half of the magnitude for the squarer
	localparam int SQW = 2 * MW;        // squared component
	localparam int SW  = SQW + 2;       // sum of three squares
	localparam int RW  = SW + 1;        // division remainder after doubling
	localparam int QW  = 2 * FB + 3;    // quotient c^2 * 2^(2F+2) / s
	localparam int DIV_STEPS = QW - 1;  // quotient bits after the leading one
	localparam int RTW = FB + 2;        // integer square root of the quotient
	localparam int RMW = RTW + 4;       // square root remainder

	// Stage map of the valid line.
	localparam int FRONT_STG = 7;
	localparam int DIV_BASE  = FRONT_STG;
	localparam int SQ_BASE   = DIV_BASE + DIV_STEPS + 1;
	localparam int OUT_STG   = SQ_BASE + RTW + 1;
	localparam int NSTG      = OUT_STG + 1;

	// Payload of one division stage.
	typedef struct packed {
		logic [SW-1:0]          s;
		logic [2:0]             neg;
		logic                   deg;
		logic [2:0][RW-1:0]     rem;
		logic [2:0][QW-1:0]     quo;
	} div_t;

	// Payload of one square root stage.
	typedef struct packed {
		logic [2:0]             neg;
		logic                   deg;
		logic [2:0][RMW-1:0]    rem;
		logic [2:0][RTW-1:0]    root;
		logic [2:0][2*RTW-1:0]  rad;
	} sqr_t;

	// One result beat.
	typedef struct packed {
		logic signed [OW-1:0] nx;
		logic signed [OW-1:0] ny;
		logic signed [OW-1:0] nz;
		logic                 deg;
	} res_t;

endpackage

`default_nettype wire

/* design/tfn_ifs.sv */
// Valid/ready channel interfaces for triangle beats in and normal beats out.
// Depends on tfn_pkg for the field widths.
`default_nettype none

interface tfn_vtx_if;
	logic                          valid;
	logic                          ready;
	logic signed [tfn_pkg::CW-1:0] a_x, a_y, a_z;
	logic signed [tfn_pkg::CW-1:0] b_x, b_y, b_z;
	logic signed [tfn_pkg::CW-1:0] c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tfn_nrm_if;
	logic                          valid;
	logic                          ready;
	logic signed [tfn_pkg::OW-1:0] norm_x, norm_y, norm_z;
	logic                          degenerate;

	modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

`default_nettype wire

/* design/triangle_face_normal_top.sv */
// Triangle face normal pipeline: throughput one triangle per cycle while the skid register is empty.
// The long restoring divider (one quotient bit per stage) and the digit-by-digit square
// root (one root bit per stage) set the depth.
// A one-beat skid register holds a result the sink refuses; the pipeline stalls while it is full.
// Asynchronous active-low reset clears the valid line and the skid register.
`default_nettype none

module triangle_face_normal_top (
	input  wire logic clk,
	input  wire logic arst_n,
	tfn_vtx_if.sink   vtx,
	tfn_nrm_if.source nrm
);
	import tfn_pkg::*;

	logic            en;
	logic [NSTG-1:0] vld_q;
	logic            skid_v_q;
	res_t            skid_q;

	logic signed [2:0][EW-1:0] e1_s1, e2_s1;
	logic signed [5:0][PW-1:0] p_s2;
	logic signed [2:0][NW-1:0] n_s3;
	logic [2:0][MW-1:0]        mag_s4;
	logic [2:0]                neg_s4, neg_s5, neg_s6, neg_s7;
	logic [2:0][2*HW-1:0]      hh_s5, hl_s5, ll_s5;
	logic [2:0][SQW-1:0]       sq_s6, sq_s7;
	logic [SW-1:0]             s_s7;
	div_t                      div_s [0:DIV_STEPS];
	sqr_t                      sq_s [0:RTW];
	res_t                      out_s;
	res_t                      res_d;

	// The whole pipeline moves unless the skid register is holding a beat.
	assign en        = !skid_v_q;
	assign vtx.ready = en;

	// Valid line: one bit per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], vtx.valid};
		end
	end

	// Stage 1: edge differences a-b and b-c.
	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= {vtx.a_x[CW-1], vtx.a_x} - {vtx.b_x[CW-1], vtx.b_x};
			e1_s1[1] <= {vtx.a_y[CW-1], vtx.a_y} - {vtx.b_y[CW-1], vtx.b_y};
			e1_s1[2] <= {vtx.a_z[CW-1], vtx.a_z} - {vtx.b_z[CW-1], vtx.b_z};
			e2_s1[0] <= {vtx.b_x[CW-1], vtx.b_x} - {vtx.c_x[CW-1], vtx.c_x};
			e2_s1[1] <= {vtx.b_y[CW-1], vtx.b_y} - {vtx.c_y[CW-1], vtx.c_y};
			e2_s1[2] <= {vtx.b_z[CW-1], vtx.b_z} - {vtx.c_z[CW-1], vtx.c_z};
		end
	end

	// Stage 2: the six signed edge products of the cross product.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= $signed(e1_s1[1]) * $signed(e2_s1[2]);
			p_s2[1] <= $signed(e1_s1[2]) * $signed(e2_s1[1]);
			p_s2[2] <= $signed(e1_s1[2]) * $signed(e2_s1[0]);
			p_s2[3] <= $signed(e1_s1[0]) * $signed(e2_s1[2]);
			p_s2[4] <= $signed(e1_s1[0]) * $signed(e2_s1[1]);
			p_s2[5] <= $signed(e1_s1[1]) * $signed(e2_s1[0]);
		end
	end

	// Stage 3: cross product components.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				n_s3[c] <= {p_s2[2*c][PW-1], p_s2[2*c]} - {p_s2[2*c+1][PW-1], p_s2[2*c+1]};
			end
		end
	end

	// Stage 4: sign and magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				neg_s4[c] <= n_s3[c][NW-1];
				mag_s4[c] <= n_s3[c][NW-1] ? MW'(-n_s3[c]) : MW'(n_s3[c]);
			end
		end
	end

	// Stage 5: partial products of each square, split into halves.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5 <= neg_s4;
			for (int c = 0; c < 3; c++) begin
				hh_s5[c] <= HW'(mag_s4[c] >> HW) * HW'(mag_s4[c] >> HW);
				hl_s5[c] <= HW'(mag_s4[c] >> HW) * mag_s4[c][HW-1:0];
				ll_s5[c] <= mag_s4[c][HW-1:0] * mag_s4[c][HW-1:0];
			end
		end
	end

	// Stage 6: recombine the partial products into full squares.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= neg_s5;
			for (int c = 0; c < 3; c++) begin
				sq_s6[c] <= (SQW'(hh_s5[c]) << (2 * HW)) + (SQW'(hl_s5[c]) << (HW + 1))
					+ SQW'(ll_s5[c]);
			end
		end
	end

	// Stage 7: squared length of the cross product.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s7 <= neg_s6;
			sq_s7  <= sq_s6;
			s_s7   <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		end
	end

	// Division head: leading quotient bit, which is set only when c^2 equals s.
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].s   <= s_s7;
			div_s[0].neg <= neg_s7;
			div_s[0].deg <= (s_s7 == '0);
			for (int c = 0; c < 3; c++) begin
				if (SW'(sq_s7[c]) >= s_s7) begin
					div_s[0].rem[c] <= RW'(SW'(sq_s7[c]) - s_s7);
					div_s[0].quo[c] <= QW'(1);
				end else begin
					div_s[0].rem[c] <= RW'(sq_s7[c]);
					div_s[0].quo[c] <= '0;
				end
			end
		end
	end

	// Restoring division: one quotient bit per stage for all three components.
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		div_t               nx;
		logic [2:0][RW-1:0] r2;
		logic [2:0]         ge;

		always_comb begin
			nx = div_s[j-1];
			for (int c = 0; c < 3; c++) begin
				r2[c]     = {div_s[j-1].rem[c][RW-2:0], 1'b0};
				ge[c]     = r2[c] >= {1'b0, div_s[j-1].s};
				nx.rem[c] = ge[c] ? r2[c] - {1'b0, div_s[j-1].s} : r2[c];
				nx.quo[c] = {div_s[j-1].quo[c][QW-2:0], ge[c]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= nx;
			end
		end
	end

	// Square root head: load the quotient as the radicand.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].neg <= div_s[DIV_STEPS].neg;
			sq_s[0].deg <= div_s[DIV_STEPS].deg;
			for (int c = 0; c < 3; c++) begin
				sq_s[0].rem[c]  <= '0;
				sq_s[0].root[c] <= '0;
				sq_s[0].rad[c]  <= (2*RTW)'(div_s[DIV_STEPS].quo[c]);
			end
		end
	end

	// Digit-by-digit square root: one root bit per stage.
	for (genvar k = 1; k <= RTW; k++) begin : g_sqrt
		sqr_t                nx;
		logic [2:0][RMW-1:0] remx;
		logic [2:0][RMW-1:0] trial;
		logic [2:0]          ge;

		always_comb begin
			nx = sq_s[k-1];
			for (int c = 0; c < 3; c++) begin
				remx[c]    = {sq_s[k-1].rem[c][RMW-3:0], sq_s[k-1].rad[c][2*RTW-1 -: 2]};
				trial[c]   = RMW'({sq_s[k-1].root[c], 2'b01});
				ge[c]      = remx[c] >= trial[c];
				nx.rem[c]  = ge[c] ? remx[c] - trial[c] : remx[c];
				nx.root[c] = {sq_s[k-1].root[c][RTW-2:0], ge[c]};
				nx.rad[c]  = {sq_s[k-1].rad[c][2*RTW-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k] <= nx;
			end
		end
	end

	// Output stage: the largest odd number not above the root gives the rounded value.
	always_comb begin
		logic [2:0][RTW:0]  r1;
		logic [2:0][OW-1:0] val;
		for (int c = 0; c < 3; c++) begin
			r1[c]  = {1'b0, sq_s[RTW].root[c]} + (RTW+1)'(1);
			val[c] = OW'(r1[c][RTW:1]);
			if (sq_s[RTW].deg) begin
				val[c] = '0;
			end else if (sq_s[RTW].neg[c]) begin
				val[c] = OW'(0) - val[c];
			end
		end
		res_d.nx  = val[0];
		res_d.ny  = val[1];
		res_d.nz  = val[2];
		res_d.deg = sq_s[RTW].deg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s <= res_d;
		end
	end

	// Skid register: catches the last stage when the sink refuses the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			skid_v_q <= vld_q[OUT_STG] && !nrm.ready;
		end else if (nrm.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= out_s;
		end
	end

	// Result channel.
	assign nrm.valid      = skid_v_q || vld_q[OUT_STG];
	assign nrm.norm_x     = skid_v_q ? skid_q.nx  : out_s.nx;
	assign nrm.norm_y     = skid_v_q ? skid_q.ny  : out_s.ny;
	assign nrm.norm_z     = skid_v_q ? skid_q.nz  : out_s.nz;
	assign nrm.degenerate = skid_v_q ? skid_q.deg : out_s.deg;

endmodule

`default_nettype wire

/* design/tfn_checker.sv */
// Port-level checker of the triangle face normal result channel, and its bind.
// Depends on tfn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tfn_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          vld,
	input wire logic                          rdy,
	input wire logic signed [tfn_pkg::OW-1:0] nx,
	input wire logic signed [tfn_pkg::OW-1:0] ny,
	input wire logic signed [tfn_pkg::OW-1:0] nz,
	input wire logic                          deg
);
	import tfn_pkg::*;

	localparam logic signed [OW-1:0] ONE = OW'(1 << FB);

	// A refused beat stays offered.
	`ASSERT_NEXT(a_hold, vld && !rdy, vld)
	// A degenerate triangle gives a zero normal.
	`ASSERT_IMPL(a_deg_zero, vld && deg, nx == '0 && ny == '0 && nz == '0)
	// Every component lies within plus and minus one.
	`ASSERT_IMPL(a_range, vld, nx <= ONE && nx >= -ONE && ny <= ONE && ny >= -ONE
		&& nz <= ONE && nz >= -ONE)
	// A proper triangle always has a non-zero component.
	`ASSERT_IMPL(a_nonzero, vld && !deg, nx != '0 || ny != '0 || nz != '0)

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.vld    (nrm.valid),
	.rdy    (nrm.ready),
	.nx     (nrm.norm_x),
	.ny     (nrm.norm_y),
	.nz     (nrm.norm_z),
	.deg    (nrm.degenerate)
);

`default_nettype wire

/* tb/sv/triangle_face_normal_top_tb.sv */
// Self-checking testbench for triangle_face_normal_top: random and directed triangles in,
// unit normals predicted in exact integer arithmetic and compared beat by beat.
// Depends on tfn_pkg, tfn_ifs and the top level of the block.
`timescale 1ns / 100ps

module triangle_face_normal_top_tb;

	import tfn_pkg::*;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t ax, ay, az;
		coord_t bx, by, bz;
		coord_t cx, cy, cz;
	} triangle_t;

	logic clk;
	logic arst_n;

	tfn_vtx_if vtx ();
	tfn_nrm_if nrm ();

	triangle_face_normal_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.nrm    (nrm)
	);

	res_t pending_normals [$];
	int   error_count;
	bit   tx_gaps;
	bit   rx_gaps;
	int   rx_hold_cycles;

	// Clock generation.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Mismatch reporting.
	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// One component scaled to Q1.14: round(|c| * 2^F / sqrt(s)), ties away from zero.
	function automatic logic [OW-1:0] unit_component(input longint c, input logic [127:0] s);
		logic [127:0] mag;
		logic [127:0] target;
		logic [127:0] k;
		logic [127:0] p;
		logic [127:0] root;
		logic [127:0] cand;
		mag = (c < 0) ? -c : c;
		target = (mag * mag) << (2 * FB + 2);
		root = 0;
		for (int b = FB; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand <= (128'd1 << FB)) begin
				k = 2 * cand - 1;
				p = k * k * s;
				if (p <= target)
					root = cand;
			end
		end
		if (c < 0)
			root = -root;
		return root[OW-1:0];
	endfunction

	// Expected normal of one triangle from the exact cross product of its edges.
	function automatic res_t face_normal(input triangle_t t);
		longint e1x, e1y, e1z, e2x, e2y, e2z;
		longint nx, ny, nz;
		logic [127:0] sum_sq;
		logic [127:0] mx, my, mz;
		res_t r;
		e1x = longint'(t.ax) - longint'(t.bx);
		e1y = longint'(t.ay) - longint'(t.by);
		e1z = longint'(t.az) - longint'(t.bz);
		e2x = longint'(t.bx) - longint'(t.cx);
		e2y = longint'(t.by) - longint'(t.cy);
		e2z = longint'(t.bz) - longint'(t.cz);
		nx = e1y * e2z - e1z * e2y;
		ny = e1z * e2x - e1x * e2z;
		nz = e1x * e2y - e1y * e2x;
		mx = (nx < 0) ? -nx : nx;
		my = (ny < 0) ? -ny : ny;
		mz = (nz < 0) ? -nz : nz;
		sum_sq = mx * mx + my * my + mz * mz;
		if (sum_sq == 0) begin
			r = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
		end else begin
			r.nx = unit_component(nx, sum_sq);
			r.ny = unit_component(ny, sum_sq);
			r.nz = unit_component(nz, sum_sq);
			r.deg = 1'b0;
		end
		return r;
	endfunction

	// Offer one triangle beat and wait until it is accepted.
	task automatic send_triangle(input triangle_t t);
		if (tx_gaps) begin
			while ($urandom_range(99) < 32) begin
				vtx.valid <= 1'b0;
				@(posedge clk);
			end
		end
		vtx.valid <= 1'b1;
		vtx.a_x <= t.ax; vtx.a_y <= t.ay; vtx.a_z <= t.az;
		vtx.b_x <= t.bx; vtx.b_y <= t.by; vtx.b_z <= t.bz;
		vtx.c_x <= t.cx; vtx.c_y <= t.cy; vtx.c_z <= t.cz;
		@(posedge clk);
		while (!vtx.ready)
			@(posedge clk);
		pending_normals.push_back(face_normal(t));
	endtask

	function automatic triangle_t make_triangle(input int ax, ay, az, bx, by, bz,
		cx, cy, cz);
		triangle_t t;
		t.ax = ax; t.ay = ay; t.az = az;
		t.bx = bx; t.by = by; t.bz = bz;
		t.cx = cx; t.cy = cy; t.cz = cz;
		return t;
	endfunction

	function automatic coord_t rand_coord(input int span);
		if (span >= 32768)
			return coord_t'($urandom);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	// A random triangle: full range, small, collinear or coincident, or axis aligned.
	function automatic triangle_t random_triangle();
		triangle_t t;
		int kind;
		int span;
		int k;
		kind = $urandom_range(9);
		span = ($urandom_range(1)) ? 32768 : (1 << $urandom_range(1, 12));
		t.ax = rand_coord(span); t.ay = rand_coord(span); t.az = rand_coord(span);
		t.bx = rand_coord(span); t.by = rand_coord(span); t.bz = rand_coord(span);
		t.cx = rand_coord(span); t.cy = rand_coord(span); t.cz = rand_coord(span);
		if (kind == 0) begin
			// Collinear: third vertex continues the first edge, with wraparound left in.
			k = $urandom_range(4) - 2;
			t.cx = t.bx + k * (t.ax - t.bx);
			t.cy = t.by + k * (t.ay - t.by);
			t.cz = t.bz + k * (t.az - t.bz);
		end else if (kind == 1) begin
			t.bx = t.ax; t.by = t.ay; t.bz = t.az;
		end else if (kind == 2) begin
			// All three vertices share one coordinate, so the normal lies on an axis.
			case ($urandom_range(2))
				0: begin t.bx = t.ax; t.cx = t.ax; end
				1: begin t.by = t.ay; t.cy = t.ay; end
				default: begin t.bz = t.az; t.cz = t.az; end
			endcase
		end
		return t;
	endfunction

	// Result sink: randomised ready, long hold-offs on request, and the checker.
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			nrm.ready <= 1'b0;
		end else begin
			if (nrm.valid && nrm.ready) begin
				got = '{nx: nrm.norm_x, ny: nrm.norm_y, nz: nrm.norm_z, deg: nrm.degenerate};
				if (pending_normals.size() == 0) begin
					report_mismatch("normal beat with none expected");
				end else begin
					want = pending_normals.pop_front();
					if (got.nx !== want.nx)
						report_mismatch($sformatf("norm_x %0d, expected %0d", got.nx, want.nx));
					if (got.ny !== want.ny)
						report_mismatch($sformatf("norm_y %0d, expected %0d", got.ny, want.ny));
					if (got.nz !== want.nz)
						report_mismatch($sformatf("norm_z %0d, expected %0d", got.nz, want.nz));
					if (got.deg !== want.deg)
						report_mismatch($sformatf("degenerate %0b, expected %0b",
							got.deg, want.deg));
				end
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles <= rx_hold_cycles - 1;
				nrm.ready <= 1'b0;
			end else begin
				nrm.ready <= rx_gaps ? ($urandom_range(99) >= 32) : 1'b1;
			end
		end
	end

	// Wait until every expected normal has arrived.
	task automatic wait_for_drain();
		while (pending_normals.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the coordinates, axis-aligned normals and degenerate triangles.
	task automatic test_directed();
		send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768));
		send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 256, 256, 0));
		send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 0, 256, 256));
		send_triangle(make_triangle(0, 0, 0, 0, 0, 256, 256, 0, 256));
		send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 256, -256, 0));
		send_triangle(make_triangle(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768));
		send_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
			-32768, -32768, 32767));
		send_triangle(make_triangle(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
		send_triangle(make_triangle(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		send_triangle(make_triangle(32767, 32767, 32767, -32768, -32768, -32768,
			0, 0, 0));
		send_triangle(make_triangle(1, 0, 0, 0, 0, 0, 0, 1, 0));
		send_triangle(make_triangle(1, 2, 3, 1, 2, 3, 7, 8, 9));
		send_triangle(make_triangle(-1, -1, -1, 0, 0, 0, 1, 1, 1));
		send_triangle(make_triangle(32767, -32768, 0, -32768, 32767, 0, 32767, 32767, 1));
		send_triangle(make_triangle(0, 0, 0, 1, 1, 0, 2, 1, 1));
		send_triangle(make_triangle(-32768, -32768, 0, 32767, -32768, 0, 32767, 32767, 0));
		send_triangle(make_triangle(100, 200, 300, 400, 500, 600, 700, 800, 901));
	endtask

	// Random triangles with gaps on both sides, or with none.
	task automatic test_random(input int count, input bit gaps);
		tx_gaps = gaps;
		rx_gaps = gaps;
		repeat (count)
			send_triangle(random_triangle());
	endtask

	// The sink holds off while triangles keep coming, so the pipeline fills and stalls.
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		// Withdraw the last beat so that it is not taken a second time.
		vtx.valid <= 1'b0;
		@(posedge clk);
		rx_hold_cycles <= 300;
		repeat (120)
			send_triangle(random_triangle());
		vtx.valid <= 1'b0;
		wait_for_drain();
		rx_gaps = 1'b1;
	endtask

	// Stimulus and end of run.
	initial begin
		error_count = 0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		rx_hold_cycles = 0;
		arst_n = 1'b0;
		vtx.valid = 1'b0;
		vtx.a_x = '0; vtx.a_y = '0; vtx.a_z = '0;
		vtx.b_x = '0; vtx.b_y = '0; vtx.b_z = '0;
		vtx.c_x = '0; vtx.c_y = '0; vtx.c_z = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(600, 1'b1);
		test_backpressure();
		test_random(400, 1'b0);
		test_random(630, 1'b1);
		vtx.valid <= 1'b0;

		wait_for_drain();
		repeat (80)
			@(posedge clk);
		if (error_count == 0 && pending_normals.size() == 0)
			$display("triangle_face_normal_top verification clean");
		else
			$display("triangle_face_normal_top verification failed");
		$finish;
	end

	// Overall time limit.
	initial begin
		#5ms;
		$display("triangle_face_normal_top verification failed");
		$finish;
	end

endmodule
